FILE: hw/rtl/packet_sequence_reorder_window_defines.svh
// Assertion helpers for the checker file of the reorder window.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef PACKET_SEQUENCE_REORDER_WINDOW_DEFINES_SVH
`define PACKET_SEQUENCE_REORDER_WINDOW_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define PSRW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent starting in the cycle after its antecedent
`define PSRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/psrw_pkg.sv
package psrw_pkg;

    // Field widths
    localparam int SEQ_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int DISP_W   = 3;
    localparam int LOST_W   = 15;
    localparam int THR_W    = 6;

    localparam int WINDOW_DEFAULT = 32;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

    // Disposition codes carried by the closing status beat
    typedef enum logic [DISP_W-1:0] {
        DISP_COLLECTED = 3'd0,
        DISP_IN_ORDER  = 3'd1,
        DISP_AHEAD     = 3'd2,
        DISP_LATE      = 3'd3,
        DISP_DUPLICATE = 3'd4,
        DISP_SLOT_BUSY = 3'd5
    } disp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  load_in;
        logic  mod_mul;
        logic  mod_sub;
        logic  mod_fix;
        logic  rd_slot;
        logic  rd_base;
        logic  latch_match;
        logic  init_window;
        logic  store;
        logic  take_base;
        logic  release_base;
        logic  skip_base;
        logic  emit_rel;
        logic  emit_stat;
        logic  set_disp;
        disp_t disp;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full_at_slot;
        logic full_at_base;
        logic seq_match;
        logic d_zero;
        logic d_neg;
        logic d_beyond;
        logic held_zero;
        logic thr_reached;
        logic out_free;
        logic quota_left;
    } status_t;

endpackage

FILE: hw/rtl/psrw_stream_if.sv
// Packet channel: one packet per beat
interface psrw_in_if;
    import psrw_pkg::*;

    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    sequence_number;
    logic [HANDLE_W-1:0] packet_handle;

    modport source (output valid, output sequence_number, output packet_handle,
                    input ready);
    modport sink   (input valid, input sequence_number, input packet_handle,
                    output ready);
endinterface

// Result channel: release beats followed by one status beat per packet
interface psrw_out_if;
    import psrw_pkg::*;

    logic                valid;
    logic                ready;
    logic                item_kind;
    logic [HANDLE_W-1:0] released_handle;
    logic [SEQ_W-1:0]    released_sequence;
    logic [DISP_W-1:0]   disposition;
    logic [LOST_W-1:0]   lost_in_step;
    logic                last_of_run;

    modport source (output valid, output item_kind, output released_handle,
                    output released_sequence, output disposition,
                    output lost_in_step, output last_of_run, input ready);
    modport sink   (input valid, input item_kind, input released_handle,
                    input released_sequence, input disposition,
                    input lost_in_step, input last_of_run, output ready);
endinterface

FILE: hw/rtl/psrw_ctrl.sv
module psrw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psrw_pkg::status_t status,
    output psrw_pkg::cmd_t    cmd
);
    import psrw_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_MUL      = 14'b00000000000010,
        ST_SUB      = 14'b00000000000100,
        ST_FIX      = 14'b00000000001000,
        ST_RDS      = 14'b00000000010000,
        ST_CMP      = 14'b00000000100000,
        ST_DEC      = 14'b00000001000000,
        ST_THR      = 14'b00000010000000,
        ST_RUN_CHK  = 14'b00000100000000,
        ST_RUN_EMIT = 14'b00001000000000,
        ST_FL_CHK   = 14'b00010000000000,
        ST_FL_EMIT  = 14'b00100000000000,
        ST_FL_DUP   = 14'b01000000000000,
        ST_STAT     = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        PH_AWAIT   = 2'd0,
        PH_COLLECT = 2'd1,
        PH_ACTIVE  = 2'd2
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Sequence one packet through slot lookup, decision and release runs
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mod_mul = 1'b1;
                state_next  = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.mod_sub = 1'b1;
                state_next  = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.mod_fix = 1'b1;
                state_next  = ST_RDS;
            end
            ST_RDS:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.latch_match = 1'b1;
                state_next      = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.set_disp = 1'b1;
                unique case (phase_reg)
                    PH_AWAIT:
                    begin
                        // First packet opens the window as its base
                        cmd.init_window = 1'b1;
                        cmd.store       = 1'b1;
                        cmd.take_base   = 1'b1;
                        cmd.disp        = DISP_COLLECTED;
                        phase_next      = PH_COLLECT;
                        state_next      = ST_STAT;
                    end
                    PH_COLLECT:
                    begin
                        if (!status.full_at_slot)
                        begin
                            cmd.store     = 1'b1;
                            cmd.take_base = status.d_neg;
                            cmd.disp      = DISP_COLLECTED;
                        end
                        else
                        begin
                            cmd.disp = DISP_SLOT_BUSY;
                        end
                        state_next = ST_THR;
                    end
                    default:
                    begin
                        // Active phase; the unused code behaves the same
                        priority if (status.d_zero)
                        begin
                            cmd.store  = 1'b1;
                            cmd.disp   = DISP_IN_ORDER;
                            state_next = ST_RUN_CHK;
                        end
                        else if (status.d_neg)
                        begin
                            cmd.disp   = DISP_LATE;
                            state_next = ST_STAT;
                        end
                        else if (status.d_beyond)
                        begin
                            cmd.set_disp = 1'b0;
                            state_next   = ST_FL_CHK;
                        end
                        else
                        begin
                            if (status.full_at_slot && status.seq_match)
                            begin
                                cmd.disp = DISP_DUPLICATE;
                            end
                            else
                            begin
                                cmd.store = 1'b1;
                                cmd.disp  = DISP_AHEAD;
                            end
                            state_next = ST_STAT;
                        end
                    end
                endcase
            end
            ST_THR:
            begin
                if (status.thr_reached)
                begin
                    phase_next = PH_ACTIVE;
                    state_next = ST_RUN_CHK;
                end
                else
                begin
                    state_next = ST_STAT;
                end
            end
            ST_RUN_CHK:
            begin
                // Stop the run at an empty base slot
                if (status.held_zero || !status.full_at_base)
                begin
                    state_next = ST_STAT;
                end
                else
                begin
                    cmd.rd_base = 1'b1;
                    state_next  = ST_RUN_EMIT;
                end
            end
            ST_RUN_EMIT:
            begin
                if (!status.quota_left || status.out_free)
                begin
                    cmd.release_base = 1'b1;
                    cmd.emit_rel     = status.quota_left;
                    state_next       = ST_RUN_CHK;
                end
            end
            ST_FL_CHK:
            begin
                // Advance the base until the packet fits the window
                priority if (!status.d_beyond)
                begin
                    state_next = ST_FL_DUP;
                end
                else if (status.full_at_base)
                begin
                    cmd.rd_base = 1'b1;
                    state_next  = ST_FL_EMIT;
                end
                else
                begin
                    cmd.skip_base = 1'b1;
                end
            end
            ST_FL_EMIT:
            begin
                if (!status.quota_left || status.out_free)
                begin
                    cmd.release_base = 1'b1;
                    cmd.emit_rel     = status.quota_left;
                    state_next       = ST_FL_CHK;
                end
            end
            ST_FL_DUP:
            begin
                cmd.set_disp = 1'b1;
                if (status.full_at_slot && status.seq_match)
                begin
                    cmd.disp = DISP_DUPLICATE;
                end
                else
                begin
                    cmd.store = 1'b1;
                    cmd.disp  = DISP_AHEAD;
                end
                state_next = ST_RUN_CHK;
            end
            ST_STAT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_stat = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_AWAIT;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: hw/rtl/psrw_datapath.sv
module psrw_datapath #(
    parameter int WINDOW = psrw_pkg::WINDOW_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_enable,
    input  logic [psrw_pkg::THR_W-1:0]    cfg_write_data,
    input  logic [psrw_pkg::SEQ_W-1:0]    in_sequence_number,
    input  logic [psrw_pkg::HANDLE_W-1:0] in_packet_handle,
    input  psrw_pkg::cmd_t                cmd,
    output psrw_pkg::status_t             status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_item_kind,
    output logic [psrw_pkg::HANDLE_W-1:0] out_released_handle,
    output logic [psrw_pkg::SEQ_W-1:0]    out_released_sequence,
    output logic [psrw_pkg::DISP_W-1:0]   out_disposition,
    output logic [psrw_pkg::LOST_W-1:0]   out_lost_in_step,
    output logic                          out_last_of_run
);
    import psrw_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int REM_W   = SLOT_W + 1;
    localparam int HELD_W  = $clog2(WINDOW + 1);
    localparam int CMP_W   = THR_W + 1;
    localparam int WORD_W  = SEQ_W + HANDLE_W;
    localparam int RECIP_W = 32;
    localparam int PROD_W  = SEQ_W + RECIP_W;
    // Reciprocal of the window for the slot reduction
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_W) / WINDOW);

    // Packet and slot lookup registers
    logic [SEQ_W-1:0]    seq_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [SEQ_W-1:0]    quot_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                match_reg;
    disp_t               disp_reg;

    // Window state
    logic [WINDOW-1:0]   full_reg, full_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic [SEQ_W-1:0]    base_reg;
    logic [SLOT_W-1:0]   base_slot_reg;
    logic [LOST_W-1:0]   lost_reg;
    logic [HELD_W-1:0]   rel_cnt_reg;
    logic [THR_W-1:0]    thr_reg;

    // Slot store and its registered read
    logic [WORD_W-1:0]   slot_mem [WINDOW];
    logic [WORD_W-1:0]   rd_data_reg;
    logic [SLOT_W-1:0]   rd_addr;

    logic                out_valid_reg;

    logic [PROD_W-1:0]   prod;
    logic [SEQ_W-1:0]    quot_times_w;
    logic [SEQ_W-1:0]    rem_full;
    logic [SLOT_W-1:0]   slot_fix;
    logic [SEQ_W-1:0]    diff;
    logic [CMP_W-1:0]    thr_eff;
    logic [SLOT_W-1:0]   base_slot_inc;
    logic                out_free;

    // Reduce the sequence number to its slot: estimate, subtract, correct
    assign prod         = PROD_W'(seq_reg) * PROD_W'(RECIP);
    assign quot_times_w = quot_reg * SEQ_W'(WINDOW);
    assign rem_full     = seq_reg - quot_times_w;
    assign slot_fix     = (rem_reg >= REM_W'(WINDOW)) ? SLOT_W'(rem_reg - REM_W'(WINDOW))
                                                      : SLOT_W'(rem_reg);

    // Signed distance from the base
    assign diff = seq_reg - base_reg;

    // Clamp the collect threshold to one through the window size
    always_comb
    begin
        priority if (thr_reg == '0)
            thr_eff = CMP_W'(1);
        else if (CMP_W'(thr_reg) > CMP_W'(WINDOW))
            thr_eff = CMP_W'(WINDOW);
        else
            thr_eff = CMP_W'(thr_reg);
    end

    // Wrap the base slot at the window end and where the sequence wraps
    assign base_slot_inc = (base_slot_reg == SLOT_W'(WINDOW - 1) || base_reg == '1)
                           ? '0 : base_slot_reg + 1'b1;
    assign out_free      = !out_valid_reg || out_ready;

    always_comb
    begin
        status.full_at_slot = full_reg[slot_reg];
        status.full_at_base = full_reg[base_slot_reg];
        status.seq_match    = match_reg;
        status.d_zero       = (diff == '0);
        status.d_neg        = diff[SEQ_W-1];
        status.d_beyond     = !diff[SEQ_W-1] && (diff >= SEQ_W'(WINDOW));
        status.held_zero    = (held_reg == '0);
        status.thr_reached  = (CMP_W'(held_reg) >= thr_eff);
        status.out_free     = out_free;
        status.quota_left   = (rel_cnt_reg < HELD_W'(WINDOW));
    end

    // Update slot flags and the held count
    always_comb
    begin
        full_next = full_reg;
        held_next = held_reg;
        if (cmd.init_window)
        begin
            full_next = '0;
            held_next = '0;
        end
        if (cmd.store)
        begin
            if (!full_next[slot_reg])
                held_next = held_next + 1'b1;
            full_next[slot_reg] = 1'b1;
        end
        if (cmd.release_base)
        begin
            full_next[base_slot_reg] = 1'b0;
            if (held_next != '0)
                held_next = held_next - 1'b1;
        end
    end

    // Control and window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg      <= '0;
            held_reg      <= '0;
            base_reg      <= '0;
            base_slot_reg <= '0;
            lost_reg      <= '0;
            rel_cnt_reg   <= '0;
            thr_reg       <= THR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
            held_reg <= held_next;
            if (cfg_write_enable)
                thr_reg <= cfg_write_data;
            // Take the packet as base or step past the base slot
            if (cmd.take_base)
            begin
                base_reg      <= seq_reg;
                base_slot_reg <= slot_reg;
            end
            else if (cmd.release_base || cmd.skip_base)
            begin
                base_reg      <= base_reg + 1'b1;
                base_slot_reg <= base_slot_inc;
            end
            if (cmd.load_in)
                lost_reg <= '0;
            else if (cmd.skip_base)
                lost_reg <= lost_reg + 1'b1;
            if (cmd.load_in)
                rel_cnt_reg <= '0;
            else if (cmd.emit_rel)
                rel_cnt_reg <= rel_cnt_reg + 1'b1;
            // Hold a beat until the sink takes it
            if (cmd.emit_rel || cmd.emit_stat)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            seq_reg    <= in_sequence_number;
            handle_reg <= in_packet_handle;
        end
        if (cmd.mod_mul)
            quot_reg <= prod[RECIP_W +: SEQ_W];
        if (cmd.mod_sub)
            rem_reg <= rem_full[REM_W-1:0];
        if (cmd.mod_fix)
            slot_reg <= slot_fix;
        if (cmd.latch_match)
            match_reg <= (rd_data_reg[WORD_W-1 -: SEQ_W] == seq_reg);
        if (cmd.set_disp)
            disp_reg <= cmd.disp;
        if (cmd.emit_rel)
        begin
            out_item_kind         <= 1'b0;
            out_released_handle   <= rd_data_reg[HANDLE_W-1:0];
            out_released_sequence <= rd_data_reg[WORD_W-1 -: SEQ_W];
            out_disposition       <= '0;
            out_lost_in_step      <= '0;
            out_last_of_run       <= 1'b0;
        end
        else if (cmd.emit_stat)
        begin
            out_item_kind         <= 1'b1;
            out_released_handle   <= '0;
            out_released_sequence <= seq_reg;
            out_disposition       <= disp_reg;
            out_lost_in_step      <= lost_reg;
            out_last_of_run       <= 1'b1;
        end
    end

    // Slot store: one write, one registered read
    assign rd_addr = cmd.rd_slot ? slot_reg : base_slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            slot_mem[slot_reg] <= {seq_reg, handle_reg};
        if (cmd.rd_slot || cmd.rd_base)
            rd_data_reg <= slot_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/packet_sequence_reorder_window.sv
// Channel   Dir  Beat contents
// packet    in   sequence_number, packet_handle
// result    out  item_kind, released_handle, released_sequence, disposition,
//                lost_in_step, last_of_run
// config    in   cfg_write_enable / cfg_write_data: initial_collect_count
//
// A packet that releases nothing passes the slot reduction (multiply,
// subtract, correct), a slot store read, the compare and the decision, plus
// a threshold check while collecting. A release run checks and emits each
// packet, then makes a closing check; a forced flush skips each hole and
// emits each held packet. A stalled result channel holds the controller where it
// is. Reset clears the slot flags at once, so no clearing pass is needed.
module packet_sequence_reorder_window #(
    parameter int WINDOW = psrw_pkg::WINDOW_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_enable,
    input  logic [psrw_pkg::THR_W-1:0] cfg_write_data,
    psrw_in_if.sink                    packet,
    psrw_out_if.source                 result
);
    import psrw_pkg::*;

    cmd_t    cmd;
    status_t status;

    psrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (packet.valid),
        .in_ready (packet.ready),
        .status   (status),
        .cmd      (cmd)
    );

    psrw_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write_enable      (cfg_write_enable),
        .cfg_write_data        (cfg_write_data),
        .in_sequence_number    (packet.sequence_number),
        .in_packet_handle      (packet.packet_handle),
        .cmd                   (cmd),
        .status                (status),
        .out_valid             (result.valid),
        .out_ready             (result.ready),
        .out_item_kind         (result.item_kind),
        .out_released_handle   (result.released_handle),
        .out_released_sequence (result.released_sequence),
        .out_disposition       (result.disposition),
        .out_lost_in_step      (result.lost_in_step),
        .out_last_of_run       (result.last_of_run)
    );

endmodule

FILE: hw/rtl/psrw_checker.sv
`include "packet_sequence_reorder_window_defines.svh"

module psrw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_item_kind,
    input logic [psrw_pkg::HANDLE_W-1:0] out_handle,
    input logic [psrw_pkg::SEQ_W-1:0]    out_sequence,
    input logic [psrw_pkg::DISP_W-1:0]   out_disposition,
    input logic [psrw_pkg::LOST_W-1:0]   out_lost,
    input logic                          out_last
);

    // Slot lookup and decision keep the packet channel closed for a while
    `PSRW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready, "packet taken too soon after previous")

    // The packet channel reopens only as the closing status beat is shown
    `PSRW_ASSERT_SAME(a_ready_with_status, $rose(in_ready), out_valid && out_item_kind && out_last, "ready rose without a status beat")

    // A stalled result beat holds its payload
    `PSRW_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_item_kind) && $stable(out_handle) && $stable(out_sequence) && $stable(out_disposition) && $stable(out_lost) && $stable(out_last), "stalled result beat changed")

endmodule

bind packet_sequence_reorder_window psrw_checker u_psrw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (packet.valid),
    .in_ready        (packet.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_item_kind   (result.item_kind),
    .out_handle      (result.released_handle),
    .out_sequence    (result.released_sequence),
    .out_disposition (result.disposition),
    .out_lost        (result.lost_in_step),
    .out_last        (result.last_of_run)
);
